// ----- hw/rtl/bss_pkg.sv -----
`timescale 1ns / 1ps

package bss_pkg;

  // Store geometry.
  localparam int TEXT_DEPTH    = 256;
  localparam int PATTERN_DEPTH = 16;
  localparam int ELEMENT_WIDTH = 8;

  // Derived widths: addresses, and lengths that can hold the depth itself.
  localparam int TADDR_W = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
  localparam int PADDR_W = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int TLEN_W  = $clog2(TEXT_DEPTH + 1);
  localparam int PLEN_W  = $clog2(PATTERN_DEPTH + 1);

  // Fixed field widths of the request and result beats.
  localparam int REQ_W     = 2;
  localparam int POS_W     = 8;
  localparam int VAL_W     = 8;
  localparam int STATUS_W  = 2;
  localparam int TLREG_W   = 9;
  localparam int PLREG_W   = 5;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;

  // Request kinds.
  localparam logic [REQ_W-1:0] REQ_WRITE_TEXT    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE_PATTERN = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH_FWD    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_SEARCH_REV    = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_FOUND       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_WRITE_OK    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_WRITE_RANGE = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LENGTH    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'd1;

  // Memory port control from the search engine.
  typedef struct packed {
    logic                     text_we;
    logic [TADDR_W-1:0]       text_waddr;
    logic [TADDR_W-1:0]       text_raddr;
    logic                     pat_we;
    logic [PADDR_W-1:0]       pat_waddr;
    logic [PADDR_W-1:0]       pat_raddr;
    logic [ELEMENT_WIDTH-1:0] wdata;
  } mem_req_t;

  // One finished result offered by the engine.
  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    match_position;
  } res_t;

endpackage

// ----- hw/rtl/bss_ram.sv -----
`timescale 1ns / 1ps

module bss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/bss_engine.sv -----
`timescale 1ns / 1ps

module bss_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bss_pkg::REQ_W-1:0]         req,
  input  logic [bss_pkg::POS_W-1:0]         pos,
  input  logic [bss_pkg::VAL_W-1:0]         val,
  input  logic [bss_pkg::TLEN_W-1:0]        tlen,
  input  logic [bss_pkg::PLEN_W-1:0]        plen,
  output bss_pkg::mem_req_t                 mem,
  input  logic [bss_pkg::ELEMENT_WIDTH-1:0] text_rdata,
  input  logic [bss_pkg::ELEMENT_WIDTH-1:0] pat_rdata,
  output bss_pkg::res_t                     res,
  input  logic                              res_ready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                       state, state_next;
  logic                             rev, rev_next;
  logic [bss_pkg::TLEN_W-1:0]       cand, cand_next;
  logic [bss_pkg::TLEN_W-1:0]       last, last_next;
  logic [bss_pkg::PLEN_W-1:0]       k, k_next;
  logic [bss_pkg::STATUS_W-1:0]     status, status_next;
  logic [bss_pkg::POS_W-1:0]        where_at, where_next;
  logic                             accept;

  // No request is taken while reset is held.
  assign in_ready = !rst && ((state == S_IDLE) || (state == S_DONE && res_ready));
  assign accept   = in_valid && in_ready;

  assign res.valid          = (state == S_DONE);
  assign res.status         = status;
  assign res.match_position = where_at;

  // Writes go to the stores on the accepting edge; reads follow the scan.
  always_comb begin
    mem.text_we    = accept && req == bss_pkg::REQ_WRITE_TEXT
                     && 32'(pos) < bss_pkg::TEXT_DEPTH;
    mem.pat_we     = accept && req == bss_pkg::REQ_WRITE_PATTERN
                     && 32'(pos) < bss_pkg::PATTERN_DEPTH;
    mem.text_waddr = bss_pkg::TADDR_W'(pos);
    mem.pat_waddr  = bss_pkg::PADDR_W'(pos);
    mem.wdata      = bss_pkg::ELEMENT_WIDTH'(val);
    mem.text_raddr = bss_pkg::TADDR_W'(32'(cand) + 32'(k));
    mem.pat_raddr  = bss_pkg::PADDR_W'(k);
  end

  always_comb begin
    logic [31:0] pos32, tlen32, plen32, at32;
    pos32       = 32'(pos);
    tlen32      = 32'(tlen);
    plen32      = 32'(plen);
    at32        = pos32;
    state_next  = state;
    rev_next    = rev;
    cand_next   = cand;
    last_next   = last;
    k_next      = k;
    status_next = status;
    where_next  = where_at;

    case (state)
      S_READ: begin
        if (k == plen) begin
          status_next = bss_pkg::ST_FOUND;
          where_next  = bss_pkg::POS_W'(cand);
          state_next  = S_DONE;
        end else begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_READ;
        if (text_rdata == pat_rdata) begin
          k_next = k + 1'b1;
        end else begin
          k_next = '0;
          if ((!rev && cand == last) || (rev && cand == '0)) begin
            status_next = bss_pkg::ST_NOT_FOUND;
            where_next  = '0;
            state_next  = S_DONE;
          end else if (rev) begin
            cand_next = cand - 1'b1;
          end else begin
            cand_next = cand + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (accept) begin
      k_next     = '0;
      where_next = '0;
      state_next = S_DONE;
      rev_next   = (req == bss_pkg::REQ_SEARCH_REV);
      case (req)
        bss_pkg::REQ_WRITE_TEXT: begin
          status_next = mem.text_we ? bss_pkg::ST_WRITE_OK : bss_pkg::ST_WRITE_RANGE;
        end
        bss_pkg::REQ_WRITE_PATTERN: begin
          status_next = mem.pat_we ? bss_pkg::ST_WRITE_OK : bss_pkg::ST_WRITE_RANGE;
        end
        bss_pkg::REQ_SEARCH_FWD: begin
          status_next = bss_pkg::ST_NOT_FOUND;
          if (pos32 + plen32 <= tlen32) begin
            cand_next  = bss_pkg::TLEN_W'(pos32);
            last_next  = bss_pkg::TLEN_W'(tlen32 - plen32);
            state_next = S_READ;
          end
        end
        default: begin
          status_next = bss_pkg::ST_NOT_FOUND;
          if (plen32 <= tlen32) begin
            if (at32 >= tlen32) begin
              at32 = (tlen32 != 0) ? tlen32 - 1 : 0;
            end
            if (at32 + plen32 > tlen32) begin
              at32 = tlen32 - plen32;
            end
            cand_next  = bss_pkg::TLEN_W'(at32);
            state_next = S_READ;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    rev      <= rev_next;
    cand     <= cand_next;
    last     <= last_next;
    k        <= k_next;
    status   <= status_next;
    where_at <= where_next;
  end

endmodule

// ----- hw/rtl/bidirectional_substring_search.sv -----
`timescale 1ns / 1ps

// Substring search over a text store and a pattern store.
// Request beats arrive on the s_ group: s_tuser carries the request kind
// (write text element, write pattern element, search forward, search
// reverse), s_tdata the position and the element value. Every request
// gives exactly one result beat on the m_ group: m_tuser is the status
// (found, not found, write accepted, write beyond capacity) and m_tdata the
// match position, zero unless found.
// The lengths of the text and of the pattern are set through the cfg_
// write port while the block is idle; the user must keep to this, as the
// block itself has no check for it. A write is stored on the accepting
// edge and its result goes out through the output register; writes can
// follow back to back while the receiver takes the results. A search
// walks the candidate positions and, for each, the pattern elements; each
// comparison passes a read state and a compare state, as both stores give
// registered read data. One request is in work at a time.
// Reset clears the lengths and the control state; the store contents stay
// undefined until written. When the receiver stalls, the finished result
// waits in the output register and the engine holds its own result.
module bidirectional_substring_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // position [7:0], element_value [15:8]
  input  logic [1:0]  s_tuser,   // req_type [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // match_position [7:0]
  output logic [1:0]  m_tuser,   // status [1:0]
  input  logic        cfg_we,
  input  logic [bss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bss_pkg::CFG_W-1:0]     cfg_data
);

  logic [bss_pkg::TLREG_W-1:0]      text_length;
  logic [bss_pkg::PLREG_W-1:0]      pattern_length;
  logic [bss_pkg::TLEN_W-1:0]       tlen;
  logic [bss_pkg::PLEN_W-1:0]       plen;
  bss_pkg::mem_req_t                mem;
  bss_pkg::res_t                    res;
  logic                             res_ready;
  logic [bss_pkg::ELEMENT_WIDTH-1:0] text_rdata;
  logic [bss_pkg::ELEMENT_WIDTH-1:0] pat_rdata;

  // Length registers; a write to an index outside the list has no effect.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_length    <= '0;
      pattern_length <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bss_pkg::CFG_TEXT_LENGTH:    text_length    <= cfg_data[bss_pkg::TLREG_W-1:0];
        bss_pkg::CFG_PATTERN_LENGTH: pattern_length <= cfg_data[bss_pkg::PLREG_W-1:0];
        default: ;
      endcase
    end
  end

  // Lengths beyond the store capacity are clipped to it.
  assign tlen = (32'(text_length) > bss_pkg::TEXT_DEPTH)
              ? bss_pkg::TLEN_W'(bss_pkg::TEXT_DEPTH)
              : bss_pkg::TLEN_W'(text_length);
  assign plen = (32'(pattern_length) > bss_pkg::PATTERN_DEPTH)
              ? bss_pkg::PLEN_W'(bss_pkg::PATTERN_DEPTH)
              : bss_pkg::PLEN_W'(pattern_length);

  bss_ram #(
    .WIDTH(bss_pkg::ELEMENT_WIDTH),
    .DEPTH(bss_pkg::TEXT_DEPTH)
  ) u_text_ram (
    .clk   (clk),
    .we    (mem.text_we),
    .waddr (mem.text_waddr),
    .wdata (mem.wdata),
    .raddr (mem.text_raddr),
    .rdata (text_rdata)
  );

  bss_ram #(
    .WIDTH(bss_pkg::ELEMENT_WIDTH),
    .DEPTH(bss_pkg::PATTERN_DEPTH)
  ) u_pattern_ram (
    .clk   (clk),
    .we    (mem.pat_we),
    .waddr (mem.pat_waddr),
    .wdata (mem.wdata),
    .raddr (mem.pat_raddr),
    .rdata (pat_rdata)
  );

  bss_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .req        (s_tuser),
    .pos        (s_tdata[7:0]),
    .val        (s_tdata[15:8]),
    .tlen       (tlen),
    .plen       (plen),
    .mem        (mem),
    .text_rdata (text_rdata),
    .pat_rdata  (pat_rdata),
    .res        (res),
    .res_ready  (res_ready)
  );

  // Output register: it takes a new result whenever it is empty or being
  // drained in the same cycle.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res.valid;
    end
    if (res_ready && res.valid) begin
      m_tuser <= res.status;
      m_tdata <= res.match_position;
    end
  end

`ifndef ASSERT_OFF
  // A write beat always yields its result on the very next cycle.
  a_write_one_cycle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready
    && (s_tuser == bss_pkg::REQ_WRITE_TEXT || s_tuser == bss_pkg::REQ_WRITE_PATTERN)
    |=> res.valid && (res.status == bss_pkg::ST_WRITE_OK
                      || res.status == bss_pkg::ST_WRITE_RANGE))
    else $error("write result did not follow its beat");

  // Only a found result carries a nonzero position.
  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != bss_pkg::ST_FOUND |-> m_tdata == '0)
    else $error("nonzero position on a result that is not a match");

  // A new request is taken only when the engine's pending result can leave.
  a_accept_drains: assert property (@(posedge clk) disable iff (rst)
    s_tready && res.valid |-> res_ready)
    else $error("request taken while a result is blocked");

  // Both stores are never written by the same beat.
  a_one_store: assert property (@(posedge clk) disable iff (rst)
    !(mem.text_we && mem.pat_we))
    else $error("both stores written at once");
`endif

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import bss_pkg::*;

  // Cycles without any accepted beat before the run is declared hung. The
  // slowest search walks 241 candidates with 16 pattern elements each, and
  // this limit leaves ample room for it.
  localparam int STALL_LIMIT = 40000;
  // Quiet cycles after the last result before a length write or the end.
  localparam int DRAIN_GUARD = 4;
  // Item counts at which the idling pattern changes.
  localparam int IDLE_SWAP_AT = 780;
  localparam int IDLE_OFF_AT  = 1560;
  localparam int PHASES = 12;

  // One result beat: status code and match position.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    spot;
  } outcome_t;

  // One row of the directed table. The lengths are programmed before the
  // row whenever they differ from the current setting. Rows with typed set
  // carry a hand-written expectation; the others take the predictor's.
  typedef struct {
    int                 tlen;
    int                 plen;
    logic [REQ_W-1:0]   kind;
    logic [POS_W-1:0]   pos;
    logic [VAL_W-1:0]   val;
    bit                 typed;
    outcome_t           want;
  } directed_row_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [15:0]          s_tdata = '0;   // position [7:0], element_value [15:8]
  logic [1:0]           s_tuser = '0;   // req_type [1:0]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;        // match_position [7:0]
  logic [1:0]           m_tuser;        // status [1:0]
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TEXT_LENGTH;
  logic [CFG_W-1:0]     cfg_data = '0;

  bidirectional_substring_search dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Shadow of the block's state, updated in the order requests are accepted.
  logic [ELEMENT_WIDTH-1:0] text_mem [TEXT_DEPTH];
  logic [ELEMENT_WIDTH-1:0] pat_mem  [PATTERN_DEPTH];
  logic [TLREG_W-1:0]       text_len_reg = '0;
  logic [PLREG_W-1:0]       pat_len_reg = '0;
  int                       cur_tlen_set = 0;
  int                       cur_plen_set = 0;

  // Results owed by the block, oldest first.
  outcome_t      awaited_outcomes [$];
  directed_row_t directed_plan [$];

  int send_idle_pct = 26;
  int recv_idle_pct = 68;
  int items_sent = 0;
  int settings_count = 0;
  int errors = 0;
  int beats_checked = 0;
  int found_count = 0;
  int missed_count = 0;
  int stored_count = 0;
  int refused_count = 0;
  int quiet_cycles = 0;
  outcome_t head;

  // Length settings of the random part. Most use short texts so searches
  // stay quick; two phases run the full store, one of them through
  // register values beyond capacity that must clamp.
  int phase_text_len [PHASES] = '{16, 32, 64, 8, 48, 24, 128, 5, 12, 256, 300, 96};
  int phase_pat_len  [PHASES] = '{1, 4, 3, 8, 0, 5, 2, 16, 12, 16, 20, 6};
  int phase_items    [PHASES] = '{220, 220, 220, 180, 150, 220, 200, 120, 180,
                                  60, 60, 200};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Lengths as the block uses them: register values past the store depth
  // behave as the depth.
  function automatic int eff_text_len();
    return (text_len_reg > TEXT_DEPTH) ? TEXT_DEPTH : int'(text_len_reg);
  endfunction

  function automatic int eff_pattern_len();
    return (pat_len_reg > PATTERN_DEPTH) ? PATTERN_DEPTH : int'(pat_len_reg);
  endfunction

  function automatic bit pattern_fits_at(int at, int plen);
    for (int k = 0; k < plen; k++) begin
      if (text_mem[at + k] != pat_mem[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Computes the result of one request and applies its effect on the stores.
  function automatic outcome_t search_outcome(logic [REQ_W-1:0] kind,
                                              logic [POS_W-1:0] pos,
                                              logic [VAL_W-1:0] val);
    outcome_t r;
    int tlen;
    int plen;
    int at;
    tlen = eff_text_len();
    plen = eff_pattern_len();
    r.status = ST_NOT_FOUND;
    r.spot = '0;
    case (kind)
      REQ_WRITE_TEXT: begin
        if (pos < TEXT_DEPTH) begin
          text_mem[pos] = val;
          r.status = ST_WRITE_OK;
        end else begin
          r.status = ST_WRITE_RANGE;
        end
      end
      REQ_WRITE_PATTERN: begin
        if (pos < PATTERN_DEPTH) begin
          pat_mem[pos[PADDR_W-1:0]] = val;
          r.status = ST_WRITE_OK;
        end else begin
          r.status = ST_WRITE_RANGE;
        end
      end
      REQ_SEARCH_FWD: begin
        // The loop does not run at all when the start is too late.
        for (int i = int'(pos); i + plen <= tlen; i++) begin
          if (pattern_fits_at(i, plen)) begin
            r.status = ST_FOUND;
            r.spot = POS_W'(i);
            break;
          end
        end
      end
      REQ_SEARCH_REV: begin
        if (plen <= tlen) begin
          // Pull the start back to the last place the pattern fits.
          at = int'(pos);
          if (at >= tlen) at = (tlen > 0) ? tlen - 1 : 0;
          if (at + plen > tlen) at = tlen - plen;
          for (int i = at; i >= 0; i--) begin
            if (pattern_fits_at(i, plen)) begin
              r.status = ST_FOUND;
              r.spot = POS_W'(i);
              break;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic void add_row(int tlen, int plen, logic [REQ_W-1:0] kind,
                                  logic [POS_W-1:0] pos, logic [VAL_W-1:0] val,
                                  bit typed, logic [STATUS_W-1:0] status,
                                  logic [POS_W-1:0] spot);
    directed_row_t row;
    row.tlen = tlen;
    row.plen = plen;
    row.kind = kind;
    row.pos = pos;
    row.val = val;
    row.typed = typed;
    row.want.status = status;
    row.want.spot = spot;
    directed_plan.push_back(row);
  endfunction

  // Offers one request beat, holds it until accepted, then records what the
  // block owes for it. The sender may idle first, depending on the phase of
  // the run. No drive happens in the step of acceptance, so the next call is
  // free to keep tvalid high with new data.
  task automatic send_request(logic [REQ_W-1:0] kind, logic [POS_W-1:0] pos,
                              logic [VAL_W-1:0] val, bit typed, outcome_t want);
    outcome_t predicted;
    if (items_sent < IDLE_SWAP_AT) begin
      send_idle_pct = 26;
      recv_idle_pct = 68;
    end else if (items_sent < IDLE_OFF_AT) begin
      send_idle_pct = 68;
      recv_idle_pct = 26;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {val, pos};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    predicted = search_outcome(kind, pos, val);
    awaited_outcomes.push_back(typed ? want : predicted);
  endtask

  // Stops offering requests until every owed result has been taken.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_GUARD) @(posedge clk);
  endtask

  // Lengths may only change while the block is idle, so drain first.
  task automatic set_lengths(int tlen, int plen);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= CFG_TEXT_LENGTH;
    cfg_data <= CFG_W'(tlen);
    @(posedge clk);
    cfg_index <= CFG_PATTERN_LENGTH;
    cfg_data <= CFG_W'(plen);
    @(posedge clk);
    cfg_we <= 1'b0;
    text_len_reg = TLREG_W'(tlen);
    pat_len_reg = PLREG_W'(plen);
    cur_tlen_set = tlen;
    cur_plen_set = plen;
    settings_count++;
  endtask

  // Start positions mostly land inside the text, now and then anywhere.
  function automatic logic [POS_W-1:0] pick_start(int tlen);
    if (tlen > 0 && $urandom_range(0, 4) != 0)
      return POS_W'($urandom_range(0, (tlen > 256) ? 255 : tlen - 1));
    return POS_W'($urandom_range(0, 255));
  endfunction

  // Random traffic under one length setting. The bulk is well-formed work:
  // a pattern copied from the current text (sometimes with one bit flipped so
  // it nearly matches) followed by a few searches. The rest is text rewrites
  // from a small alphabet, searches from arbitrary starts, and pattern writes
  // at arbitrary addresses, many of them beyond capacity.
  task automatic run_phase(int tlen_set, int plen_set, int items);
    int stop_at;
    int pick;
    int tl;
    int pl;
    int seg;
    int flip;
    int searches;
    logic [VAL_W-1:0] v;
    set_lengths(tlen_set, plen_set);
    stop_at = items_sent + items;
    while (items_sent < stop_at) begin
      tl = eff_text_len();
      pl = eff_pattern_len();
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if (pl > 0 && pl <= tl) begin
          seg = $urandom_range(0, tl - pl);
          flip = ($urandom_range(0, 3) == 0) ? $urandom_range(0, pl - 1) : -1;
          for (int k = 0; k < pl; k++) begin
            v = text_mem[seg + k];
            if (k == flip) v = v ^ VAL_W'(1 << $urandom_range(0, 7));
            send_request(REQ_WRITE_PATTERN, POS_W'(k), v, 1'b0, '0);
          end
        end
        searches = $urandom_range(1, 4);
        repeat (searches) begin
          send_request($urandom_range(0, 1) ? REQ_SEARCH_REV : REQ_SEARCH_FWD,
                       pick_start(tl), VAL_W'($urandom), 1'b0, '0);
        end
      end else if (pick < 80) begin
        v = ($urandom_range(0, 4) == 0) ? VAL_W'($urandom) : VAL_W'($urandom_range(0, 3));
        send_request(REQ_WRITE_TEXT, pick_start(tl), v, 1'b0, '0);
      end else if (pick < 90) begin
        send_request($urandom_range(0, 1) ? REQ_SEARCH_REV : REQ_SEARCH_FWD,
                     POS_W'($urandom), VAL_W'($urandom), 1'b0, '0);
      end else begin
        send_request(REQ_WRITE_PATTERN, POS_W'($urandom), VAL_W'($urandom), 1'b0, '0);
      end
      // Once in a while the sender holds back until the block has caught up.
      if ($urandom_range(0, 99) == 0) drain_results();
    end
  endtask

  // Ready toggles at random; the share of stalled cycles follows the phase.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Result checker: every accepted result beat is matched to the oldest
  // owed outcome, field by field.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_outcomes.size() == 0) begin
        $display("%0t: result beat with nothing owed, status %0d position %0d",
                 $realtime, m_tuser, m_tdata);
        errors++;
      end else begin
        head = awaited_outcomes.pop_front();
        beats_checked++;
        if (m_tuser !== head.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $realtime, head.status, m_tuser);
          errors++;
        end
        if (m_tdata !== head.spot) begin
          $display("%0t: match position mismatch, expected %0d, actual %0d",
                   $realtime, head.spot, m_tdata);
          errors++;
        end
        case (head.status)
          ST_FOUND:       found_count++;
          ST_NOT_FOUND:   missed_count++;
          ST_WRITE_OK:    stored_count++;
          ST_WRITE_RANGE: refused_count++;
        endcase
      end
    end
  end

  // Watchdog: a long stretch with no beat on either side means a hang.
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: no beat for %0d cycles", $realtime, quiet_cycles);
    $display("bidirectional_substring_search regression: fail");
    $finish;
  end

  initial begin
    // Zero lengths after reset: nothing is read from the stores, so an empty
    // pattern is found at zero, also by reverse from 255; forward from 255 fails.
    add_row(0, 0, REQ_WRITE_TEXT,    8'd0,   8'h00, 1'b1, ST_WRITE_OK,    8'd0);
    add_row(0, 0, REQ_WRITE_TEXT,    8'd255, 8'hFF, 1'b1, ST_WRITE_OK,    8'd0);
    add_row(0, 0, REQ_WRITE_PATTERN, 8'd0,   8'hFF, 1'b1, ST_WRITE_OK,    8'd0);
    add_row(0, 0, REQ_WRITE_PATTERN, 8'd15,  8'h00, 1'b1, ST_WRITE_OK,    8'd0);
    add_row(0, 0, REQ_WRITE_PATTERN, 8'd16,  8'hA5, 1'b1, ST_WRITE_RANGE, 8'd0);
    add_row(0, 0, REQ_WRITE_PATTERN, 8'd255, 8'h5A, 1'b1, ST_WRITE_RANGE, 8'd0);
    add_row(0, 0, REQ_SEARCH_FWD,    8'd0,   8'hFF, 1'b1, ST_FOUND,       8'd0);
    add_row(0, 0, REQ_SEARCH_FWD,    8'd255, 8'h00, 1'b1, ST_NOT_FOUND,   8'd0);
    add_row(0, 0, REQ_SEARCH_REV,    8'd0,   8'h00, 1'b1, ST_FOUND,       8'd0);
    add_row(0, 0, REQ_SEARCH_REV,    8'd255, 8'hFF, 1'b1, ST_FOUND,       8'd0);
    // Text x 07 09 x with pattern 07 09: the only match is at one.
    add_row(4, 2, REQ_WRITE_TEXT,    8'd1,   8'h07, 1'b1, ST_WRITE_OK,    8'd0);
    add_row(4, 2, REQ_WRITE_TEXT,    8'd2,   8'h09, 1'b1, ST_WRITE_OK,    8'd0);
    add_row(4, 2, REQ_WRITE_PATTERN, 8'd0,   8'h07, 1'b1, ST_WRITE_OK,    8'd0);
    add_row(4, 2, REQ_WRITE_PATTERN, 8'd1,   8'h09, 1'b1, ST_WRITE_OK,    8'd0);
    add_row(4, 2, REQ_SEARCH_FWD,    8'd0,   8'h00, 1'b1, ST_FOUND,       8'd1);
    add_row(4, 2, REQ_SEARCH_FWD,    8'd2,   8'h00, 1'b1, ST_NOT_FOUND,   8'd0);
    // Forward start so late that the pattern cannot fit.
    add_row(4, 2, REQ_SEARCH_FWD,    8'd3,   8'h00, 1'b1, ST_NOT_FOUND,   8'd0);
    // Reverse start past the text clamps back to two, then finds one.
    add_row(4, 2, REQ_SEARCH_REV,    8'd255, 8'h00, 1'b1, ST_FOUND,       8'd1);
    add_row(4, 2, REQ_SEARCH_REV,    8'd0,   8'h00, 1'b1, ST_NOT_FOUND,   8'd0);
    // Pattern longer than the text, in both directions.
    add_row(1, 2, REQ_SEARCH_REV,    8'd0,   8'h00, 1'b1, ST_NOT_FOUND,   8'd0);
    add_row(1, 2, REQ_SEARCH_FWD,    8'd0,   8'h00, 1'b1, ST_NOT_FOUND,   8'd0);
    // All-ones register values clamp to the store depths.
    add_row(511, 31, REQ_SEARCH_FWD, 8'd250, 8'h00, 1'b1, ST_NOT_FOUND,   8'd0);
    add_row(511, 31, REQ_SEARCH_FWD, 8'd0,   8'h00, 1'b0, ST_NOT_FOUND,   8'd0);
    add_row(511, 31, REQ_SEARCH_REV, 8'd255, 8'h00, 1'b0, ST_NOT_FOUND,   8'd0);
    // Empty pattern in a full text matches right at the start.
    add_row(256, 0, REQ_SEARCH_FWD,  8'd255, 8'h00, 1'b1, ST_FOUND,       8'd255);
    add_row(256, 0, REQ_SEARCH_REV,  8'd200, 8'h00, 1'b1, ST_FOUND,       8'd200);
    // Single element lookup.
    add_row(2, 1, REQ_SEARCH_FWD,    8'd0,   8'h00, 1'b0, ST_NOT_FOUND,   8'd0);
    add_row(2, 1, REQ_SEARCH_REV,    8'd255, 8'h00, 1'b0, ST_NOT_FOUND,   8'd0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The stores are undefined until written, so fill both completely before
    // any search can look at them. A small alphabet keeps matches common.
    for (int i = 0; i < TEXT_DEPTH; i++)
      send_request(REQ_WRITE_TEXT, POS_W'(i), VAL_W'($urandom_range(0, 3)), 1'b0, '0);
    for (int i = 0; i < PATTERN_DEPTH; i++)
      send_request(REQ_WRITE_PATTERN, POS_W'(i), VAL_W'($urandom_range(0, 3)), 1'b0, '0);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].tlen != cur_tlen_set || directed_plan[i].plen != cur_plen_set)
        set_lengths(directed_plan[i].tlen, directed_plan[i].plen);
      send_request(directed_plan[i].kind, directed_plan[i].pos, directed_plan[i].val,
                   directed_plan[i].typed, directed_plan[i].want);
    end

    for (int p = 0; p < PHASES; p++)
      run_phase(phase_text_len[p], phase_pat_len[p], phase_items[p]);

    drain_results();
    repeat (8) @(posedge clk);

    $display("Sent %0d requests under %0d length settings, %0d result beats checked.",
             items_sent, settings_count, beats_checked);
    $display("Searches: %0d found, %0d not found. Writes: %0d stored, %0d refused.",
             found_count, missed_count, stored_count, refused_count);
    if (errors == 0 && awaited_outcomes.size() == 0) begin
      $display("bidirectional_substring_search regression: pass");
    end else begin
      $display("bidirectional_substring_search regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/bss_pkg.sv
hw/rtl/bss_ram.sv
hw/rtl/bss_engine.sv
hw/rtl/bidirectional_substring_search.sv
verif/testbench.sv
